/* sv/apsr_pkg.sv */
// Shared constants, codes and types of the adaptive pixel sample refiner.
package apsr_pkg;

  localparam int unsigned COLOR_BITS           = 16;
  localparam int unsigned MAX_SAMPLE_LIMIT_DEF = 256;
  localparam int unsigned CNT_OUT_W            = 9;
  localparam int unsigned CFG_CNT_W            = 9;
  localparam int unsigned THR_W                = 32;
  localparam int unsigned LVL_W                = 4;
  localparam int unsigned CFG_IDX_W            = 4;
  localparam int unsigned CFG_DATA_W           = 32;

  localparam logic [CFG_CNT_W-1:0] BASE_RST   = 9'd4;
  localparam logic [CFG_CNT_W-1:0] MAX_RST    = 9'd64;
  localparam logic [THR_W-1:0]     THR_RST    = 32'd655;
  localparam logic [LVL_W-1:0]     LEVELS_RST = 4'd3;

  localparam logic [7:0]  LUMA_R     = 8'd77;
  localparam logic [7:0]  LUMA_G     = 8'd150;
  localparam logic [7:0]  LUMA_B     = 8'd29;
  localparam int unsigned LUMA_SHIFT = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE   = 4'd0,
    CFG_MAX    = 4'd1,
    CFG_THRESH = 4'd2,
    CFG_LEVELS = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_MORE  = 1'b0,
    KIND_FINAL = 1'b1
  } result_kind_e;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_e;

  typedef struct packed {
    logic    start;
    mdu_op_e op;
  } mdu_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LUMA,
    ST_SQR,
    ST_ACC,
    ST_DECIDE,
    ST_LHS,
    ST_SQ,
    ST_NN1,
    ST_RHS,
    ST_CMP,
    ST_DIVR,
    ST_DIVG,
    ST_DIVB,
    ST_EMIT
  } state_e;

endpackage

/* sv/apsr_if.sv */
// Handshake interfaces for the sample, result and configuration channels.
interface apsr_sample_if import apsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] red;
  logic [COLOR_BITS-1:0] green;
  logic [COLOR_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface apsr_result_if import apsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [0:0]            result_kind;
  logic [CNT_OUT_W-1:0]  more_samples;
  logic [COLOR_BITS-1:0] avg_red;
  logic [COLOR_BITS-1:0] avg_green;
  logic [COLOR_BITS-1:0] avg_blue;
  logic [CNT_OUT_W-1:0]  samples_used;

  modport source (output valid, result_kind, more_samples, avg_red, avg_green, avg_blue,
                  samples_used, input ready);
  modport sink (input valid, result_kind, more_samples, avg_red, avg_green, avg_blue,
                samples_used, output ready);
endinterface

interface apsr_cfg_if import apsr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/apsr_mdu.sv */
// Bit-serial multiply and restoring divide unit sharing one adder.
module apsr_mdu import apsr_pkg::*; #(
  parameter int unsigned PROD_W = 50,
  parameter int unsigned MPLR_W = 25,
  parameter int unsigned DIV_W  = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mdu_ctrl_t         ctrl_i,
  input  logic [PROD_W-1:0] mcand_i,
  input  logic [MPLR_W-1:0] mplier_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o,
  output logic [DIV_W-1:0]  quot_o
);

  localparam int unsigned STEP_W = $clog2(MPLR_W + 1);

  logic              busy_q, busy_d;
  mdu_op_e           op_q, op_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] mcand_q, mcand_d;
  logic [MPLR_W-1:0] mplier_q, mplier_d;

  logic [PROD_W-1:0] rem_shift;
  logic [PROD_W-1:0] add_x;
  logic [PROD_W-1:0] add_y;
  logic              add_cin;
  logic [PROD_W:0]   add_sum;

  assign rem_shift = {acc_q[PROD_W-2:0], mplier_q[DIV_W-1]};

  always_comb begin
    if (op_q == MDU_DIV) begin
      add_x   = rem_shift;
      add_y   = ~mcand_q;
      add_cin = 1'b1;
    end else begin
      add_x   = acc_q;
      add_y   = mplier_q[0] ? mcand_q : '0;
      add_cin = 1'b0;
    end
  end

  assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{PROD_W{1'b0}}, add_cin};

  assign done_o = busy_q && (cnt_q == '0);
  assign prod_o = acc_q;
  assign quot_o = mplier_q[DIV_W-1:0];

  always_comb begin
    busy_d   = busy_q;
    op_d     = op_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    if (ctrl_i.start) begin
      busy_d   = 1'b1;
      op_d     = ctrl_i.op;
      acc_d    = '0;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      cnt_d    = (ctrl_i.op == MDU_DIV) ? STEP_W'(DIV_W) : STEP_W'(MPLR_W);
    end else if (done_o) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (op_q == MDU_DIV) begin
        acc_d    = add_sum[PROD_W] ? add_sum[PROD_W-1:0] : rem_shift;
        mplier_d = {mplier_q[MPLR_W-2:0], add_sum[PROD_W]};
      end else begin
        acc_d    = add_sum[PROD_W-1:0];
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= MDU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

endmodule

/* sv/adaptive_pixel_sample_refiner.sv */
// Top level of the adaptive pixel sample refiner: accumulation, sequencer and result register.
// A sample that does not complete the current target passes the luma, square, accumulate and
// decide states and returns to idle. At the target the variance check runs four multiplies and
// the final color three divides on the shared bit-serial multiply/divide unit. A result waits in
// the output register while the next sample is accepted; a new result stalls only while the
// previous one has not been taken. Configuration writes are always accepted.
module adaptive_pixel_sample_refiner import apsr_pkg::*; #(
  parameter int unsigned MAX_SAMPLE_LIMIT = MAX_SAMPLE_LIMIT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  apsr_cfg_if.sink      cfg_i,
  apsr_sample_if.sink   sample_i,
  apsr_result_if.source result_o
);

  localparam int unsigned CW  = $clog2(MAX_SAMPLE_LIMIT + 1);
  localparam int unsigned SW  = COLOR_BITS + CW;
  localparam int unsigned YW  = 2 * COLOR_BITS;
  localparam int unsigned S2W = YW + CW;
  localparam int unsigned NW  = 2 * CW;
  localparam int unsigned PW  = NW + ((YW > THR_W) ? YW : THR_W);
  localparam int unsigned BW  = (SW > NW) ? SW : NW;
  localparam int unsigned LW  = COLOR_BITS + LUMA_SHIFT;

  function automatic logic [CW-1:0] clamp_cnt(input logic [CFG_CNT_W-1:0] v);
    if (v == '0) begin
      return CW'(1);
    end else if (32'(v) > MAX_SAMPLE_LIMIT) begin
      return CW'(MAX_SAMPLE_LIMIT);
    end else begin
      return CW'(v);
    end
  endfunction

  state_e state_q, state_d;
  logic   started_q, started_d;

  logic [CFG_CNT_W-1:0] base_q, base_d;
  logic [CFG_CNT_W-1:0] max_q, max_d;
  logic [THR_W-1:0]     thr_q, thr_d;
  logic [LVL_W-1:0]     lvl_lim_q, lvl_lim_d;

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    target_q, target_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic [SW-1:0]    sum_r_q, sum_r_d;
  logic [SW-1:0]    sum_g_q, sum_g_d;
  logic [SW-1:0]    sum_b_q, sum_b_d;
  logic [SW-1:0]    sum_y_q, sum_y_d;
  logic [S2W-1:0]   sum_y2_q, sum_y2_d;

  logic [COLOR_BITS-1:0] r_q, r_d, g_q, g_d, b_q, b_d;
  logic [COLOR_BITS-1:0] y_q, y_d;
  logic [YW-1:0]         ysq_q, ysq_d;
  logic [PW-1:0]         diff_q, diff_d;
  logic                  pos_q, pos_d;
  logic [NW-1:0]         nn1_q, nn1_d;
  logic                  hi_q, hi_d;

  logic [0:0]            pk_q, pk_d;
  logic [CNT_OUT_W-1:0]  pmore_q, pmore_d;
  logic [CNT_OUT_W-1:0]  pused_q, pused_d;
  logic [COLOR_BITS-1:0] pavg_r_q, pavg_r_d;
  logic [COLOR_BITS-1:0] pavg_g_q, pavg_g_d;
  logic [COLOR_BITS-1:0] pavg_b_q, pavg_b_d;

  logic                  out_valid_q, out_valid_d;
  logic [0:0]            out_kind_q, out_kind_d;
  logic [CNT_OUT_W-1:0]  out_more_q, out_more_d;
  logic [CNT_OUT_W-1:0]  out_used_q, out_used_d;
  logic [COLOR_BITS-1:0] out_r_q, out_r_d;
  logic [COLOR_BITS-1:0] out_g_q, out_g_d;
  logic [COLOR_BITS-1:0] out_b_q, out_b_d;

  mdu_ctrl_t       mdu_ctrl;
  logic [PW-1:0]   mdu_mcand;
  logic [BW-1:0]   mdu_mplier;
  logic            mdu_done;
  logic [PW-1:0]   mdu_prod;
  logic [SW-1:0]   mdu_quot;

  logic            in_acc;
  logic            out_free;
  logic [CW-1:0]   cap;
  logic [CW-1:0]   count_m1;
  logic [CW:0]     target_x2;
  logic [CW-1:0]   next_tgt;
  logic [LW-1:0]   luma_full;
  logic            need_check;
  logic            at_target;

  assign in_acc    = sample_i.valid && sample_i.ready;
  assign out_free  = !out_valid_q || result_o.ready;
  assign cap       = clamp_cnt(max_q);
  assign count_m1  = count_q - CW'(1);
  assign target_x2 = {target_q, 1'b0};
  assign next_tgt  = (target_x2 > {1'b0, cap}) ? cap : target_x2[CW-1:0];
  assign luma_full = LW'(r_q) * LW'(LUMA_R) + LW'(g_q) * LW'(LUMA_G) + LW'(b_q) * LW'(LUMA_B);
  assign at_target = (count_q >= target_q);
  assign need_check = (level_q < lvl_lim_q) && (target_q < cap) && (count_q >= CW'(2));

  assign sample_i.ready        = (state_q == ST_IDLE);
  assign cfg_i.ready           = 1'b1;
  assign result_o.valid        = out_valid_q;
  assign result_o.result_kind  = out_kind_q;
  assign result_o.more_samples = out_more_q;
  assign result_o.samples_used = out_used_q;
  assign result_o.avg_red      = out_r_q;
  assign result_o.avg_green    = out_g_q;
  assign result_o.avg_blue     = out_b_q;

  apsr_mdu #(
    .PROD_W (PW),
    .MPLR_W (BW),
    .DIV_W  (SW)
  ) u_mdu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mdu_ctrl),
    .mcand_i  (mdu_mcand),
    .mplier_i (mdu_mplier),
    .done_o   (mdu_done),
    .prod_o   (mdu_prod),
    .quot_o   (mdu_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_LUMA;
      ST_LUMA:   state_d = ST_SQR;
      ST_SQR:    state_d = ST_ACC;
      ST_ACC:    state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!at_target) begin
          state_d = ST_IDLE;
        end else if (need_check) begin
          state_d = ST_LHS;
        end else begin
          state_d = ST_DIVR;
        end
      end
      ST_LHS:    if (mdu_done) state_d = ST_SQ;
      ST_SQ:     if (mdu_done) state_d = ST_NN1;
      ST_NN1:    if (mdu_done) state_d = ST_RHS;
      ST_RHS:    if (mdu_done) state_d = ST_CMP;
      ST_CMP:    state_d = hi_q ? ST_EMIT : ST_DIVR;
      ST_DIVR:   if (mdu_done) state_d = ST_DIVG;
      ST_DIVG:   if (mdu_done) state_d = ST_DIVB;
      ST_DIVB:   if (mdu_done) state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    base_d      = base_q;
    max_d       = max_q;
    thr_d       = thr_q;
    lvl_lim_d   = lvl_lim_q;
    started_d   = started_q;
    count_d     = count_q;
    target_d    = target_q;
    level_d     = level_q;
    sum_r_d     = sum_r_q;
    sum_g_d     = sum_g_q;
    sum_b_d     = sum_b_q;
    sum_y_d     = sum_y_q;
    sum_y2_d    = sum_y2_q;
    r_d         = r_q;
    g_d         = g_q;
    b_d         = b_q;
    y_d         = y_q;
    ysq_d       = ysq_q;
    diff_d      = diff_q;
    pos_d       = pos_q;
    nn1_d       = nn1_q;
    hi_d        = hi_q;
    pk_d        = pk_q;
    pmore_d     = pmore_q;
    pused_d     = pused_q;
    pavg_r_d    = pavg_r_q;
    pavg_g_d    = pavg_g_q;
    pavg_b_d    = pavg_b_q;
    out_valid_d = out_valid_q;
    out_kind_d  = out_kind_q;
    out_more_d  = out_more_q;
    out_used_d  = out_used_q;
    out_r_d     = out_r_q;
    out_g_d     = out_g_q;
    out_b_d     = out_b_q;
    mdu_ctrl    = '{start: 1'b0, op: MDU_MUL};
    mdu_mcand   = '0;
    mdu_mplier  = '0;

    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_BASE:   base_d    = cfg_i.data[CFG_CNT_W-1:0];
        CFG_MAX:    max_d     = cfg_i.data[CFG_CNT_W-1:0];
        CFG_THRESH: thr_d     = cfg_i.data[THR_W-1:0];
        CFG_LEVELS: lvl_lim_d = cfg_i.data[LVL_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          r_d = sample_i.red;
          g_d = sample_i.green;
          b_d = sample_i.blue;
          if (count_q == '0 && level_q == '0) begin
            target_d = clamp_cnt(base_q);
          end
        end
      end
      ST_LUMA: begin
        y_d     = luma_full[LW-1:LUMA_SHIFT];
        sum_r_d = sum_r_q + SW'(r_q);
        sum_g_d = sum_g_q + SW'(g_q);
        sum_b_d = sum_b_q + SW'(b_q);
      end
      ST_SQR: begin
        ysq_d   = YW'(y_q) * YW'(y_q);
        sum_y_d = sum_y_q + SW'(y_q);
      end
      ST_ACC: begin
        sum_y2_d = sum_y2_q + S2W'(ysq_q);
        count_d  = count_q + CW'(1);
      end
      ST_DECIDE: begin
        pused_d = CNT_OUT_W'(count_q);
      end
      ST_LHS, ST_SQ, ST_NN1, ST_RHS, ST_DIVR, ST_DIVG, ST_DIVB: begin
        mdu_ctrl.start = !started_q;
        started_d      = 1'b1;
        case (state_q)
          ST_LHS: begin
            mdu_mcand  = PW'(sum_y2_q);
            mdu_mplier = BW'(count_q);
          end
          ST_SQ: begin
            mdu_mcand  = PW'(sum_y_q);
            mdu_mplier = BW'(sum_y_q);
          end
          ST_NN1: begin
            mdu_mcand  = PW'(count_q);
            mdu_mplier = BW'(count_m1);
          end
          ST_RHS: begin
            mdu_mcand  = PW'(thr_q);
            mdu_mplier = BW'(nn1_q);
          end
          ST_DIVR: begin
            mdu_ctrl.op = MDU_DIV;
            mdu_mcand   = PW'(count_q);
            mdu_mplier  = BW'(sum_r_q);
          end
          ST_DIVG: begin
            mdu_ctrl.op = MDU_DIV;
            mdu_mcand   = PW'(count_q);
            mdu_mplier  = BW'(sum_g_q);
          end
          default: begin
            mdu_ctrl.op = MDU_DIV;
            mdu_mcand   = PW'(count_q);
            mdu_mplier  = BW'(sum_b_q);
          end
        endcase
        if (mdu_done) begin
          started_d = 1'b0;
          case (state_q)
            ST_LHS:  diff_d   = mdu_prod;
            ST_SQ: begin
              pos_d  = diff_q > mdu_prod;
              diff_d = diff_q - mdu_prod;
            end
            ST_NN1:  nn1_d    = NW'(mdu_prod);
            ST_RHS:  hi_d     = pos_q && (diff_q > mdu_prod);
            ST_DIVR: pavg_r_d = COLOR_BITS'(mdu_quot);
            ST_DIVG: pavg_g_d = COLOR_BITS'(mdu_quot);
            default: begin
              pavg_b_d = COLOR_BITS'(mdu_quot);
              pk_d     = KIND_FINAL;
              pmore_d  = '0;
              count_d  = '0;
              level_d  = '0;
              sum_r_d  = '0;
              sum_g_d  = '0;
              sum_b_d  = '0;
              sum_y_d  = '0;
              sum_y2_d = '0;
              target_d = clamp_cnt(base_q);
            end
          endcase
        end
      end
      ST_CMP: begin
        if (hi_q) begin
          pk_d     = KIND_MORE;
          pmore_d  = CNT_OUT_W'(next_tgt - count_q);
          pavg_r_d = '0;
          pavg_g_d = '0;
          pavg_b_d = '0;
          target_d = next_tgt;
          level_d  = level_q + LVL_W'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = pk_q;
          out_more_d  = pmore_q;
          out_used_d  = pused_q;
          out_r_d     = pavg_r_q;
          out_g_d     = pavg_g_q;
          out_b_d     = pavg_b_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      base_q      <= BASE_RST;
      max_q       <= MAX_RST;
      thr_q       <= THR_RST;
      lvl_lim_q   <= LEVELS_RST;
      count_q     <= '0;
      target_q    <= clamp_cnt(BASE_RST);
      level_q     <= '0;
      sum_r_q     <= '0;
      sum_g_q     <= '0;
      sum_b_q     <= '0;
      sum_y_q     <= '0;
      sum_y2_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      base_q      <= base_d;
      max_q       <= max_d;
      thr_q       <= thr_d;
      lvl_lim_q   <= lvl_lim_d;
      count_q     <= count_d;
      target_q    <= target_d;
      level_q     <= level_d;
      sum_r_q     <= sum_r_d;
      sum_g_q     <= sum_g_d;
      sum_b_q     <= sum_b_d;
      sum_y_q     <= sum_y_d;
      sum_y2_q    <= sum_y2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    g_q      <= g_d;
    b_q      <= b_d;
    y_q      <= y_d;
    ysq_q    <= ysq_d;
    diff_q   <= diff_d;
    pos_q    <= pos_d;
    nn1_q    <= nn1_d;
    hi_q     <= hi_d;
    pk_q     <= pk_d;
    pmore_q  <= pmore_d;
    pused_q  <= pused_d;
    pavg_r_q <= pavg_r_d;
    pavg_g_q <= pavg_g_d;
    pavg_b_q <= pavg_b_d;
    out_kind_q <= out_kind_d;
    out_more_q <= out_more_d;
    out_used_q <= out_used_d;
    out_r_q    <= out_r_d;
    out_g_q    <= out_g_d;
    out_b_q    <= out_b_d;
  end

`ifndef ASSERT_OFF
  a_count_le_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= target_q)
    else $error("sample count passed target");

  a_mdu_done_in_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_done |-> (state_q == ST_LHS || state_q == ST_SQ || state_q == ST_NN1 ||
                  state_q == ST_RHS || state_q == ST_DIVR || state_q == ST_DIVG ||
                  state_q == ST_DIVB))
    else $error("arithmetic unit finished outside an operation state");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && pk_q == KIND_FINAL) |=>
      (count_q == '0 && level_q == '0))
    else $error("pixel state not cleared after final color");
`endif

endmodule

/* dv/tb_adaptive_pixel_sample_refiner.sv */
// Self-checking testbench for the adaptive pixel sample refiner: directed cases and random traffic against a model.
`timescale 1ns / 100ps

module tb_adaptive_pixel_sample_refiner;
  import apsr_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1050;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'hF;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } sample_t;

  typedef struct packed {
    result_kind_e          kind;
    logic [CNT_OUT_W-1:0]  more;
    logic [COLOR_BITS-1:0] avg_red;
    logic [COLOR_BITS-1:0] avg_green;
    logic [COLOR_BITS-1:0] avg_blue;
    logic [CNT_OUT_W-1:0]  used;
  } pixel_result_t;

  typedef enum {MIX_RANDOM, MIX_NOISY, MIX_FLAT, MIX_RAILS} sample_mix_e;

  localparam sample_t WHITE = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
  localparam sample_t BLACK = '{16'h0000, 16'h0000, 16'h0000};
  localparam sample_t GRAY  = '{16'h8000, 16'h8000, 16'h8000};

  logic clk_i;
  logic rst_ni;

  apsr_cfg_if    cfg_bus ();
  apsr_sample_if smp_bus ();
  apsr_result_if res_bus ();

  adaptive_pixel_sample_refiner uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .sample_i (smp_bus),
    .result_o (res_bus)
  );

  sample_t       pending_samples[$];
  pixel_result_t expected_results[$];
  sample_t       on_offer;
  int unsigned   tx_idle_pct;
  int unsigned   rx_idle_pct;
  int unsigned   mismatch_count;
  logic          rx_hold;
  logic          hold_arm;

  // pixel accumulator state and register copies
  logic [CFG_CNT_W-1:0] reg_base;
  logic [CFG_CNT_W-1:0] reg_max;
  logic [THR_W-1:0]     reg_thresh;
  logic [LVL_W-1:0]     reg_levels;
  logic [CFG_CNT_W-1:0] acc_count;
  logic [CFG_CNT_W-1:0] acc_target;
  logic [LVL_W-1:0]     acc_level;
  logic [63:0]          sum_red;
  logic [63:0]          sum_green;
  logic [63:0]          sum_blue;
  logic [63:0]          sum_luma;
  logic [63:0]          sum_luma_sq;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic void enqueue_sample(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  function automatic logic [CFG_CNT_W-1:0] clamp_count(logic [CFG_CNT_W-1:0] v);
    if (v == 0) return CFG_CNT_W'(1);
    if (v > MAX_SAMPLE_LIMIT_DEF) return CFG_CNT_W'(MAX_SAMPLE_LIMIT_DEF);
    return v;
  endfunction

  function automatic void clear_pixel();
    acc_count   = '0;
    acc_level   = '0;
    sum_red     = '0;
    sum_green   = '0;
    sum_blue    = '0;
    sum_luma    = '0;
    sum_luma_sq = '0;
    acc_target  = clamp_count(reg_base);
  endfunction

  function automatic void update_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_BASE:   reg_base = val[CFG_CNT_W-1:0];
      CFG_MAX:    reg_max = val[CFG_CNT_W-1:0];
      CFG_THRESH: reg_thresh = val[THR_W-1:0];
      CFG_LEVELS: reg_levels = val[LVL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void accumulate_sample(sample_t s);
    logic [63:0]          luma, n, lhs, sq, rhs;
    logic [CFG_CNT_W:0]   next;
    logic [CFG_CNT_W-1:0] cap;
    logic                 refine;
    pixel_result_t        res;
    if (acc_count == 0 && acc_level == 0) acc_target = clamp_count(reg_base);
    luma = (64'(LUMA_R) * s.red + 64'(LUMA_G) * s.green + 64'(LUMA_B) * s.blue) >> LUMA_SHIFT;
    sum_red     += s.red;
    sum_green   += s.green;
    sum_blue    += s.blue;
    sum_luma    += luma;
    sum_luma_sq += luma * luma;
    acc_count++;
    if (acc_count < acc_target) return;
    cap    = clamp_count(reg_max);
    n      = 64'(acc_count);
    refine = 1'b0;
    if (acc_level < reg_levels && acc_target < cap && n >= 2) begin
      lhs    = n * sum_luma_sq;
      sq     = sum_luma * sum_luma;
      rhs    = 64'(reg_thresh) * n * (n - 1);
      refine = (lhs > sq) && ((lhs - sq) > rhs);
    end
    res = '0;
    res.used = acc_count;
    if (refine) begin
      next = {1'b0, acc_target} << 1;
      if (next > cap) next = {1'b0, cap};
      res.kind   = KIND_MORE;
      res.more   = CFG_CNT_W'(next - acc_count);
      acc_target = CFG_CNT_W'(next);
      acc_level++;
    end else begin
      res.kind      = KIND_FINAL;
      res.avg_red   = COLOR_BITS'(sum_red / n);
      res.avg_green = COLOR_BITS'(sum_green / n);
      res.avg_blue  = COLOR_BITS'(sum_blue / n);
      clear_pixel();
    end
    expected_results.insert(expected_results.size(), res);
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void score_result();
    pixel_result_t want;
    pixel_result_t got;
    got.kind      = result_kind_e'(res_bus.result_kind);
    got.more      = res_bus.more_samples;
    got.avg_red   = res_bus.avg_red;
    got.avg_green = res_bus.avg_green;
    got.avg_blue  = res_bus.avg_blue;
    got.used      = res_bus.samples_used;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual %0h", $time, got);
      return;
    end
    want = expected_results.pop_front();
    compare_field("result_kind", want.kind, got.kind);
    compare_field("more_samples", want.more, got.more);
    compare_field("avg_red", want.avg_red, got.avg_red);
    compare_field("avg_green", want.avg_green, got.avg_green);
    compare_field("avg_blue", want.avg_blue, got.avg_blue);
    compare_field("samples_used", want.used, got.used);
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      smp_bus.valid <= 1'b0;
    end else begin
      if (smp_bus.valid && smp_bus.ready) accumulate_sample(on_offer);
      if (!smp_bus.valid || smp_bus.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          on_offer = pending_samples.pop_front();
          smp_bus.valid <= 1'b1;
          smp_bus.red   <= on_offer.red;
          smp_bus.green <= on_offer.green;
          smp_bus.blue  <= on_offer.blue;
        end else begin
          smp_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) score_result();
      res_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // hold off the result side once for a long stretch
  initial begin
    rx_hold = 1'b0;
    wait (hold_arm);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic settle();
    while (pending_samples.size() != 0 || smp_bus.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    update_reg(idx, val);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] max,
                              logic [CFG_DATA_W-1:0] thresh, logic [CFG_DATA_W-1:0] levels);
    write_reg(CFG_BASE, base);
    write_reg(CFG_MAX, max);
    write_reg(CFG_THRESH, thresh);
    write_reg(CFG_LEVELS, levels);
  endtask

  task automatic set_idle(int unsigned tx_pct, int unsigned rx_pct);
    @(posedge clk_i);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
  endtask

  function automatic logic [COLOR_BITS-1:0] jitter(logic [COLOR_BITS-1:0] c, int unsigned spread);
    int v;
    v = int'(c) + int'($urandom_range(0, spread)) - int'(spread / 2);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return COLOR_BITS'(v);
  endfunction

  function automatic sample_t draw_sample(sample_mix_e mix, sample_t center, int unsigned spread);
    sample_t s;
    case (mix)
      MIX_RANDOM: s = sample_t'(48'({$urandom, $urandom}));
      MIX_NOISY: begin
        s.red   = jitter(center.red, spread);
        s.green = jitter(center.green, spread);
        s.blue  = jitter(center.blue, spread);
      end
      MIX_FLAT: s = center;
      default: begin
        s.red   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        s.green = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        s.blue  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
    endcase
    return s;
  endfunction

  function automatic void queue_pixels(int unsigned count);
    sample_mix_e mix;
    sample_t     center;
    int unsigned spread, run, pick;
    while (count != 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) mix = MIX_RANDOM;
      else if (pick < 7) mix = MIX_NOISY;
      else if (pick < 9) mix = MIX_FLAT;
      else mix = MIX_RAILS;
      center = sample_t'(48'({$urandom, $urandom}));
      spread = (1 << $urandom_range(0, 16)) - 1;
      run    = $urandom_range(1, 48);
      if (run > count) run = count;
      repeat (run) enqueue_sample(draw_sample(mix, center, spread));
      count -= run;
    end
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count(int unsigned typical_hi);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom & ~32'h1FF;
    if ($urandom_range(0, 9) == 0) return junk | $urandom_range(0, 511);
    return junk | $urandom_range(0, typical_hi);
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin
    int unsigned random_sent;
    int unsigned phase_len;
    logic        pressure_done;
    rst_ni         = 1'b0;
    hold_arm       = 1'b0;
    tx_idle_pct    = 17;
    rx_idle_pct    = 47;
    mismatch_count = 0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    smp_bus.valid  = 1'b0;
    smp_bus.red    = '0;
    smp_bus.green  = '0;
    smp_bus.blue   = '0;
    res_bus.ready  = 1'b0;
    reg_base       = BASE_RST;
    reg_max        = MAX_RST;
    reg_thresh     = THR_RST;
    reg_levels     = LEVELS_RST;
    clear_pixel();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset defaults, flat pixel
    repeat (4) enqueue_sample(GRAY);
    settle();

    // single-sample pixels: no variance with fewer than two samples
    apply_config(1, 4, 0, 15);
    enqueue_sample(WHITE);
    enqueue_sample(BLACK);
    enqueue_sample('{16'hFFFF, 16'h0000, 16'h5A5A});
    settle();

    // refine once, then stop at the cap
    apply_config(2, 4, 0, 15);
    repeat (2) begin
      enqueue_sample(WHITE);
      enqueue_sample(BLACK);
    end
    settle();

    // stop on level limit
    write_reg(CFG_LEVELS, 0);
    enqueue_sample(WHITE);
    enqueue_sample(BLACK);
    settle();

    // base above max
    apply_config(3, 2, 0, 15);
    enqueue_sample(WHITE);
    enqueue_sample(BLACK);
    enqueue_sample(WHITE);
    settle();

    // zero counts act as one
    apply_config(0, 0, 0, 15);
    enqueue_sample(BLACK);
    settle();

    // top threshold and oversized max
    apply_config(2, 511, 32'hFFFF_FFFF, 15);
    enqueue_sample(WHITE);
    enqueue_sample(BLACK);
    settle();

    // unmapped index, then a threshold change in the middle of a pixel
    write_reg(CFG_UNMAPPED, $urandom);
    apply_config(4, 8, 0, 15);
    enqueue_sample(WHITE);
    enqueue_sample(BLACK);
    settle();
    write_reg(CFG_THRESH, 32'hFFFF_FFFF);
    enqueue_sample(WHITE);
    enqueue_sample(BLACK);
    settle();

    random_sent   = 0;
    pressure_done = 1'b0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) set_idle(17, 47);
      else if (random_sent < 2 * RANDOM_ITEMS / 3) set_idle(47, 17);
      else set_idle(0, 0);
      settle();
      if (!pressure_done && random_sent >= 2 * RANDOM_ITEMS / 3) begin
        // one result per sample while the result side stalls
        apply_config(1, 1, pick_threshold(), $urandom_range(0, 15));
        queue_pixels(60);
        hold_arm      = 1'b1;
        random_sent  += 60;
        pressure_done = 1'b1;
      end else begin
        apply_config(pick_count(12), pick_count(40), pick_threshold(), $urandom);
        phase_len    = $urandom_range(40, 120);
        queue_pixels(phase_len);
        random_sent += phase_len;
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
